### design/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types, constants and helper functions of the report header deframer.
// ----------------------------------------------------------------------------
package rhd_pkg;

    // Largest payload buffer. Valid frame lengths are 1 .. PAYLOAD_BUF-1.
    localparam int PAYLOAD_BUF = 512;
    // Parameter characters taken after the header before the list is closed.
    localparam int PARAM_CHARS = 31;

    // Length magnitude saturates at PAYLOAD_BUF, so it needs room for that value.
    localparam int LEN_W = $clog2(PAYLOAD_BUF + 1);
    // Payload bytes still to go, at most PAYLOAD_BUF-1.
    localparam int BL_W  = (PAYLOAD_BUF > 2) ? $clog2(PAYLOAD_BUF) : 1;
    localparam int PC_W  = $clog2(PARAM_CHARS + 1);
    localparam int SOCK_W = 16;

    localparam logic [LEN_W-1:0] LEN_SAT   = LEN_W'(PAYLOAD_BUF);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(PAYLOAD_BUF - 1);
    localparam logic [PC_W-1:0]  PC_LIMIT  = PC_W'(PARAM_CHARS);
    localparam logic [SOCK_W-1:0] SOCK_SAT = 16'h8000;
    localparam logic [SOCK_W-1:0] SOCK_POS_MAX = 16'h7FFF;

    // Character codes.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PARAM,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        ST_NUM1,
        ST_SIGN1,
        ST_DIG1,
        ST_NUM2,
        ST_SIGN2,
        ST_DIG2,
        ST_DONE,
        ST_FAIL
    } num_step_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         data_byte;
        logic signed [15:0] socket_id;
        logic               last;
    } result_t;

    // Characters of the header "+SKRPTM:".
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h2B;  // '+'
            3'd1:    c = 8'h53;  // 'S'
            3'd2:    c = 8'h4B;  // 'K'
            3'd3:    c = 8'h52;  // 'R'
            3'd4:    c = 8'h50;  // 'P'
            3'd5:    c = 8'h54;  // 'T'
            3'd6:    c = 8'h4D;  // 'M'
            default: c = 8'h3A;  // ':'
        endcase
        return c;
    endfunction

    // Signed socket id from sign and saturated magnitude.
    function automatic logic signed [15:0] socket_bits(input logic neg,
                                                       input logic [SOCK_W-1:0] mag);
        logic [SOCK_W-1:0] m;
        m = mag;
        if (neg) begin
            return $signed(SOCK_W'(16'h0000 - m));
        end
        if (m > SOCK_POS_MAX) begin
            m = SOCK_POS_MAX;
        end
        return $signed(m);
    endfunction

endpackage

### design/report_header_deframer.sv
// ----------------------------------------------------------------------------
// report_header_deframer
// Finds "+SKRPTM:" report headers in a received byte stream, parses the
// socket and length parameters and forwards the payload bytes or a drop.
// ----------------------------------------------------------------------------
// Path: a byte accepted into the input register is parsed combinationally
// from there, and its result is loaded into the result register when the
// byte is consumed, which an output stall can hold off.
// Throughput: one byte per cycle while the output does not stall; an
// output stall holds the input in the same cycle.
// Reset: rst_n clears both stage valid flags and the parser, which then
// hunts for a header from its first character.
module report_header_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [7:0]         data_byte,
    output logic signed [15:0] socket_id,
    output logic               last
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              slot_free;
    logic              fire;
    logic              res_valid;
    rhd_pkg::result_t  res;
    rhd_pkg::result_t  out_res;

    // A held byte is consumed whenever the result register can take a result.
    assign fire = byte_valid && slot_free;

    rhd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .fire       (fire),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    rhd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    rhd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind      = out_res.kind;
    assign data_byte = out_res.data_byte;
    assign socket_id = out_res.socket_id;
    assign last      = out_res.last;

endmodule

### design/rhd_in_stage.sv
// ----------------------------------------------------------------------------
// rhd_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module rhd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       fire,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // A new byte may enter while the held one is being consumed.
    assign in_stall = valid_reg && !fire;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

### design/rhd_parser.sv
// ----------------------------------------------------------------------------
// rhd_parser
// Header hunt, parameter parse and payload count for one byte per cycle while bytes are consumed.
// ----------------------------------------------------------------------------
module rhd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        byte_data,
    output logic              res_valid,
    output rhd_pkg::result_t  res
);

    rhd_pkg::phase_t              phase_reg,  phase_next;
    logic [2:0]                   hpos_reg,   hpos_next;
    logic [rhd_pkg::PC_W-1:0]     count_reg,  count_next;
    rhd_pkg::num_step_t           step_reg,   step_next;
    logic [rhd_pkg::SOCK_W-1:0]   sock_reg,   sock_next;
    logic                         sneg_reg,   sneg_next;
    logic [rhd_pkg::LEN_W-1:0]    len_reg,    len_next;
    logic                         lneg_reg,   lneg_next;
    logic [rhd_pkg::BL_W-1:0]     left_reg,   left_next;

    logic                         is_ws;
    logic                         is_dig;
    logic [3:0]                   digit;
    logic [19:0]                  sock_acc;
    logic [rhd_pkg::SOCK_W-1:0]   sock_add;
    logic [rhd_pkg::LEN_W+3:0]    len_acc;
    logic [rhd_pkg::LEN_W-1:0]    len_add;
    logic                         finish;
    logic                         params_ok;

    assign is_ws  = (byte_data == rhd_pkg::CH_SPACE) || (byte_data == rhd_pkg::CH_TAB) ||
                    (byte_data == rhd_pkg::CH_VT) || (byte_data == rhd_pkg::CH_FF);
    assign is_dig = (byte_data >= rhd_pkg::CH_ZERO) && (byte_data <= rhd_pkg::CH_NINE);
    assign digit  = is_dig ? 4'(byte_data - rhd_pkg::CH_ZERO) : 4'd0;

    // Decimal accumulate, value*10 + digit, saturating.
    assign sock_acc = ({4'd0, sock_reg} << 3) + ({4'd0, sock_reg} << 1) + 20'(digit);
    assign sock_add = (sock_acc > 20'(rhd_pkg::SOCK_SAT)) ? rhd_pkg::SOCK_SAT
                                                          : sock_acc[rhd_pkg::SOCK_W-1:0];
    assign len_acc  = ({4'd0, len_reg} << 3) + ({4'd0, len_reg} << 1) +
                      (rhd_pkg::LEN_W+4)'(digit);
    assign len_add  = (len_acc > (rhd_pkg::LEN_W+4)'(rhd_pkg::LEN_SAT)) ? rhd_pkg::LEN_SAT
                                                          : len_acc[rhd_pkg::LEN_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        count_next = count_reg;
        step_next  = step_reg;
        sock_next  = sock_reg;
        sneg_next  = sneg_reg;
        len_next   = len_reg;
        lneg_next  = lneg_reg;
        left_next  = left_reg;
        finish     = 1'b0;
        params_ok  = 1'b0;
        res_valid  = 1'b0;
        res        = '0;

        case (phase_reg)
            rhd_pkg::PH_PARAM:
            begin
                if (byte_data == rhd_pkg::CH_COLON)
                begin
                    finish = 1'b1;
                end
                else if ((byte_data != rhd_pkg::CH_CR) && (byte_data != rhd_pkg::CH_LF))
                begin
                    case (step_reg)
                        rhd_pkg::ST_NUM1:
                        begin
                            if (!is_ws)
                            begin
                                if (byte_data == rhd_pkg::CH_PLUS)
                                begin
                                    step_next = rhd_pkg::ST_SIGN1;
                                end
                                else if (byte_data == rhd_pkg::CH_MINUS)
                                begin
                                    sneg_next = 1'b1;
                                    step_next = rhd_pkg::ST_SIGN1;
                                end
                                else if (is_dig)
                                begin
                                    sock_next = sock_add;
                                    step_next = rhd_pkg::ST_DIG1;
                                end
                                else
                                begin
                                    step_next = rhd_pkg::ST_FAIL;
                                end
                            end
                        end
                        rhd_pkg::ST_SIGN1:
                        begin
                            if (is_dig)
                            begin
                                sock_next = sock_add;
                                step_next = rhd_pkg::ST_DIG1;
                            end
                            else
                            begin
                                step_next = rhd_pkg::ST_FAIL;
                            end
                        end
                        rhd_pkg::ST_DIG1:
                        begin
                            if (is_dig)
                            begin
                                sock_next = sock_add;
                            end
                            else if (byte_data == rhd_pkg::CH_COMMA)
                            begin
                                step_next = rhd_pkg::ST_NUM2;
                            end
                            else
                            begin
                                step_next = rhd_pkg::ST_FAIL;
                            end
                        end
                        rhd_pkg::ST_NUM2:
                        begin
                            if (!is_ws)
                            begin
                                if (byte_data == rhd_pkg::CH_PLUS)
                                begin
                                    step_next = rhd_pkg::ST_SIGN2;
                                end
                                else if (byte_data == rhd_pkg::CH_MINUS)
                                begin
                                    lneg_next = 1'b1;
                                    step_next = rhd_pkg::ST_SIGN2;
                                end
                                else if (is_dig)
                                begin
                                    len_next  = len_add;
                                    step_next = rhd_pkg::ST_DIG2;
                                end
                                else
                                begin
                                    step_next = rhd_pkg::ST_FAIL;
                                end
                            end
                        end
                        rhd_pkg::ST_SIGN2:
                        begin
                            if (is_dig)
                            begin
                                len_next  = len_add;
                                step_next = rhd_pkg::ST_DIG2;
                            end
                            else
                            begin
                                step_next = rhd_pkg::ST_FAIL;
                            end
                        end
                        rhd_pkg::ST_DIG2:
                        begin
                            if (is_dig)
                            begin
                                len_next = len_add;
                            end
                            else
                            begin
                                step_next = rhd_pkg::ST_DONE;
                            end
                        end
                        default:
                        begin
                            step_next = step_reg;
                        end
                    endcase
                    count_next = count_reg + 1'b1;
                    // A full run of characters closes the list, standing in for ':'.
                    if (count_next >= rhd_pkg::PC_LIMIT)
                    begin
                        finish = 1'b1;
                    end
                end
            end

            rhd_pkg::PH_PAYLOAD:
            begin
                res_valid      = 1'b1;
                res.kind       = rhd_pkg::KIND_DATA;
                res.data_byte  = byte_data;
                res.socket_id  = rhd_pkg::socket_bits(sneg_reg, sock_reg);
                res.last       = (left_reg <= rhd_pkg::BL_W'(1));
                if (left_reg != '0)
                begin
                    left_next = left_reg - 1'b1;
                end
                if (left_next == '0)
                begin
                    phase_next = rhd_pkg::PH_HUNT;
                    hpos_next  = 3'd0;
                end
            end

            default:
            begin
                // Header hunt; the unused phase code behaves the same way.
                phase_next = rhd_pkg::PH_HUNT;
                if (byte_data == rhd_pkg::hdr_char(hpos_reg))
                begin
                    hpos_next = hpos_reg + 3'd1;
                    if (hpos_reg == 3'd7)
                    begin
                        phase_next = rhd_pkg::PH_PARAM;
                        count_next = '0;
                        step_next  = rhd_pkg::ST_NUM1;
                        sock_next  = '0;
                        sneg_next  = 1'b0;
                        len_next   = '0;
                        lneg_next  = 1'b0;
                    end
                end
                else
                begin
                    hpos_next = (byte_data == rhd_pkg::CH_PLUS) ? 3'd1 : 3'd0;
                end
            end
        endcase

        if (finish)
        begin
            params_ok = ((step_next == rhd_pkg::ST_DIG2) || (step_next == rhd_pkg::ST_DONE)) &&
                        !lneg_next && (len_next != '0) && (len_next <= rhd_pkg::LEN_MAX);
            hpos_next = 3'd0;
            if (params_ok)
            begin
                phase_next = rhd_pkg::PH_PAYLOAD;
                left_next  = len_next[rhd_pkg::BL_W-1:0];
            end
            else
            begin
                phase_next    = rhd_pkg::PH_HUNT;
                res_valid     = 1'b1;
                res.kind      = rhd_pkg::KIND_DROP;
                res.data_byte = 8'd0;
                res.socket_id = rhd_pkg::socket_bits(sneg_next, sock_next);
                res.last      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rhd_pkg::PH_HUNT;
            hpos_reg  <= 3'd0;
            count_reg <= '0;
            step_reg  <= rhd_pkg::ST_NUM1;
            sock_reg  <= '0;
            sneg_reg  <= 1'b0;
            len_reg   <= '0;
            lneg_reg  <= 1'b0;
            left_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            sock_reg  <= sock_next;
            sneg_reg  <= sneg_next;
            len_reg   <= len_next;
            lneg_reg  <= lneg_next;
            left_reg  <= left_next;
        end
    end

    // In the payload phase at least one byte is always still owed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rhd_pkg::PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with no bytes left");

    // Every byte consumed in the payload phase produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (phase_reg == rhd_pkg::PH_PAYLOAD)) |-> res_valid)
        else $error("payload byte without result");

    // A drop result always closes the frame and returns to the hunt.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && (res.kind == rhd_pkg::KIND_DROP)) |=>
        (res_valid == res_valid) && (phase_reg == rhd_pkg::PH_HUNT))
        else $error("drop result did not return to header hunt");

    // Parser state only moves when a byte is consumed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(phase_reg) && $stable(left_reg) && $stable(count_reg)))
        else $error("parser state changed without a consumed byte");

endmodule

### design/rhd_out_stage.sv
// ----------------------------------------------------------------------------
// rhd_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rhd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               res_valid,
    input  rhd_pkg::result_t   res,
    output logic               slot_free,
    output logic               out_valid,
    input  logic               out_stall,
    output rhd_pkg::result_t   out_res
);

    logic              valid_reg;
    logic              valid_next;
    rhd_pkg::result_t  res_reg;

    // The slot can be refilled in the same cycle its transaction completes.
    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = res_valid;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for report_header_deframer. Bytes are pushed through
// a valid/stall channel with random gaps. A scoreboard tracks the parser
// state and predicts every payload or drop result, and the results are
// checked in order as they leave the block under random backpressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] HEADER    = "+SKRPTM:";
    localparam logic [31:0] BLANKS    = {rhd_pkg::CH_SPACE, rhd_pkg::CH_TAB,
                                         rhd_pkg::CH_VT, rhd_pkg::CH_FF};
    localparam int          RAND_ITEMS = 1200;
    localparam int          CALM_FROM  = 1050;
    localparam int          DRAIN_CYCLES = 10;

    class frame_scoreboard;
        rhd_pkg::result_t   expected_q[$];
        int                 errors;
        rhd_pkg::phase_t    phase;
        logic [3:0]         hdr_pos;
        int unsigned        param_cnt;
        rhd_pkg::num_step_t step;
        int unsigned        sock_mag;
        int unsigned        len_mag;
        int unsigned        left;
        bit                 sock_neg;
        bit                 len_neg;

        function new();
            errors    = 0;
            phase     = rhd_pkg::PH_HUNT;
            hdr_pos   = 4'd0;
            param_cnt = 0;
            step      = rhd_pkg::ST_NUM1;
            sock_mag  = 0;
            len_mag   = 0;
            left      = 0;
            sock_neg  = 1'b0;
            len_neg   = 1'b0;
        endfunction

        function int unsigned sat_digit(int unsigned mag, int unsigned d, int unsigned cap);
            int unsigned v;
            v = mag * 10 + d;
            return (v > cap) ? cap : v;
        endfunction

        function logic signed [15:0] socket_out();
            logic [15:0] v;
            if (sock_neg)
            begin
                v = 16'(sock_mag);
                v = -v;
            end
            else
            begin
                v = (sock_mag > 32767) ? 16'h7FFF : 16'(sock_mag);
            end
            return $signed(v);
        endfunction

        function void close_params();
            rhd_pkg::result_t r;
            hdr_pos = 4'd0;
            if ((step == rhd_pkg::ST_DIG2 || step == rhd_pkg::ST_DONE) && !len_neg &&
                len_mag >= 1 && len_mag <= rhd_pkg::PAYLOAD_BUF - 1)
            begin
                phase = rhd_pkg::PH_PAYLOAD;
                left  = len_mag;
            end
            else
            begin
                phase       = rhd_pkg::PH_HUNT;
                r.kind      = rhd_pkg::KIND_DROP;
                r.data_byte = 8'h00;
                r.socket_id = socket_out();
                r.last      = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        // Advances the parser by one accepted byte and queues any result it causes.
        function void note_byte(logic [7:0] b);
            rhd_pkg::result_t r;
            bit               blank;
            bit               digit;
            int unsigned      d;
            blank = (b == rhd_pkg::CH_SPACE || b == rhd_pkg::CH_TAB ||
                     b == rhd_pkg::CH_VT || b == rhd_pkg::CH_FF);
            digit = (b >= rhd_pkg::CH_ZERO && b <= rhd_pkg::CH_NINE);
            d     = digit ? int'(b - rhd_pkg::CH_ZERO) : 0;
            case (phase)
                rhd_pkg::PH_PARAM:
                begin
                    if (b == rhd_pkg::CH_COLON)
                    begin
                        close_params();
                    end
                    else if (b != rhd_pkg::CH_CR && b != rhd_pkg::CH_LF)
                    begin
                        case (step)
                            rhd_pkg::ST_NUM1:
                            begin
                                if (blank)
                                begin
                                end
                                else if (b == rhd_pkg::CH_PLUS)
                                begin
                                    step = rhd_pkg::ST_SIGN1;
                                end
                                else if (b == rhd_pkg::CH_MINUS)
                                begin
                                    sock_neg = 1'b1;
                                    step     = rhd_pkg::ST_SIGN1;
                                end
                                else if (digit)
                                begin
                                    sock_mag = sat_digit(sock_mag, d, 32768);
                                    step     = rhd_pkg::ST_DIG1;
                                end
                                else
                                begin
                                    step = rhd_pkg::ST_FAIL;
                                end
                            end
                            rhd_pkg::ST_SIGN1:
                            begin
                                if (digit)
                                begin
                                    sock_mag = sat_digit(sock_mag, d, 32768);
                                    step     = rhd_pkg::ST_DIG1;
                                end
                                else
                                begin
                                    step = rhd_pkg::ST_FAIL;
                                end
                            end
                            rhd_pkg::ST_DIG1:
                            begin
                                if (digit)
                                begin
                                    sock_mag = sat_digit(sock_mag, d, 32768);
                                end
                                else if (b == rhd_pkg::CH_COMMA)
                                begin
                                    step = rhd_pkg::ST_NUM2;
                                end
                                else
                                begin
                                    step = rhd_pkg::ST_FAIL;
                                end
                            end
                            rhd_pkg::ST_NUM2:
                            begin
                                if (blank)
                                begin
                                end
                                else if (b == rhd_pkg::CH_PLUS)
                                begin
                                    step = rhd_pkg::ST_SIGN2;
                                end
                                else if (b == rhd_pkg::CH_MINUS)
                                begin
                                    len_neg = 1'b1;
                                    step    = rhd_pkg::ST_SIGN2;
                                end
                                else if (digit)
                                begin
                                    len_mag = sat_digit(len_mag, d, rhd_pkg::PAYLOAD_BUF);
                                    step    = rhd_pkg::ST_DIG2;
                                end
                                else
                                begin
                                    step = rhd_pkg::ST_FAIL;
                                end
                            end
                            rhd_pkg::ST_SIGN2:
                            begin
                                if (digit)
                                begin
                                    len_mag = sat_digit(len_mag, d, rhd_pkg::PAYLOAD_BUF);
                                    step    = rhd_pkg::ST_DIG2;
                                end
                                else
                                begin
                                    step = rhd_pkg::ST_FAIL;
                                end
                            end
                            rhd_pkg::ST_DIG2:
                            begin
                                if (digit)
                                begin
                                    len_mag = sat_digit(len_mag, d, rhd_pkg::PAYLOAD_BUF);
                                end
                                else
                                begin
                                    step = rhd_pkg::ST_DONE;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        param_cnt++;
                        if (param_cnt >= rhd_pkg::PARAM_CHARS)
                        begin
                            close_params();
                        end
                    end
                end
                rhd_pkg::PH_PAYLOAD:
                begin
                    r.kind      = rhd_pkg::KIND_DATA;
                    r.data_byte = b;
                    r.socket_id = socket_out();
                    r.last      = (left <= 1);
                    expected_q.push_back(r);
                    if (left > 0)
                    begin
                        left--;
                    end
                    if (left == 0)
                    begin
                        phase   = rhd_pkg::PH_HUNT;
                        hdr_pos = 4'd0;
                    end
                end
                default:
                begin
                    phase = rhd_pkg::PH_HUNT;
                    if (b == HEADER[8 * (7 - hdr_pos[2:0]) +: 8])
                    begin
                        hdr_pos++;
                        if (hdr_pos >= 4'd8)
                        begin
                            hdr_pos   = 4'd0;
                            phase     = rhd_pkg::PH_PARAM;
                            param_cnt = 0;
                            step      = rhd_pkg::ST_NUM1;
                            sock_mag  = 0;
                            sock_neg  = 1'b0;
                            len_mag   = 0;
                            len_neg   = 1'b0;
                        end
                    end
                    else
                    begin
                        hdr_pos = (b == rhd_pkg::CH_PLUS) ? 4'd1 : 4'd0;
                    end
                end
            endcase
        endfunction

        function void check_result(logic k, logic [7:0] db, logic signed [15:0] sid,
                                   logic lst);
            rhd_pkg::result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d data_byte %02h socket_id %0d last %0d",
                       k, db, sid, lst);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (k !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, k);
                errors++;
            end
            if (db !== e.data_byte)
            begin
                $error("data_byte: expected %02h, actual %02h", e.data_byte, db);
                errors++;
            end
            if (sid !== e.socket_id)
            begin
                $error("socket_id: expected %0d, actual %0d", e.socket_id, sid);
                errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0d, actual %0d", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte   = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               kind;
    logic [7:0]         data_byte;
    logic signed [15:0] socket_id;
    logic               last;

    frame_scoreboard sb = new();

    int          items     = 0;
    bit          quiet     = 1'b0;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 10;
    int unsigned stall_run = 0;
    int unsigned rx_cycle  = 0;
    logic [7:0]  param_text[$];

    report_header_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .socket_id (socket_id),
        .last      (last)
    );

    always #10 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: check every accepted result, refresh the stall level and drive out_stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(kind, data_byte, socket_id, last);
        end
        rx_cycle++;
        if (rx_cycle % 128 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 35;
            endcase
        end
        if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                stall_run = $urandom_range(1, 7);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_byte(b);
        items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // Hold the sender off until every predicted result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic void put_number(int unsigned val, int unsigned minus_pct);
        string       s;
        int unsigned r;
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 2))
            begin
                param_text.push_back(BLANKS[8 * $urandom_range(0, 3) +: 8]);
            end
        end
        r = $urandom_range(0, 99);
        if (r < minus_pct)
        begin
            param_text.push_back(rhd_pkg::CH_MINUS);
        end
        else if (r < minus_pct + 15)
        begin
            param_text.push_back(rhd_pkg::CH_PLUS);
        end
        // A number with no digits, after a sign or not, must fail the parse.
        if ($urandom_range(0, 99) < 3)
        begin
            return;
        end
        if ($urandom_range(0, 99) < 10)
        begin
            repeat ($urandom_range(1, 3)) param_text.push_back(rhd_pkg::CH_ZERO);
        end
        s = $sformatf("%0d", val);
        for (int i = 0; i < s.len(); i++)
        begin
            param_text.push_back(s[i]);
        end
    endfunction

    task automatic send_frame();
        int unsigned r;
        int unsigned sock;
        int unsigned len;
        int          bad;
        logic [7:0]  c;
        case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 8;
            default: gap_pct = 30;
        endcase
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 7))
            begin
                send_byte(HEADER[8 * (7 - $urandom_range(0, 7)) +: 8]);
            end
        end

        bad = ($urandom_range(0, 99) < 8) ? int'($urandom_range(0, 7)) : -1;
        for (int i = 0; i < 8; i++)
        begin
            c = (i == bad) ? 8'($urandom_range(0, 255)) : HEADER[8 * (7 - i) +: 8];
            send_byte(c);
        end

        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            sock = $urandom_range(0, 9);
        end
        else if (r < 80)
        begin
            sock = $urandom_range(10, 999);
        end
        else if (r < 90)
        begin
            sock = $urandom_range(32760, 32775);
        end
        else
        begin
            sock = $urandom_range(99990, 9999999);
        end

        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            len = $urandom_range(1, 12);
        end
        else if (r < 87)
        begin
            len = $urandom_range(13, 64);
        end
        else if (r < 89)
        begin
            len = rhd_pkg::PAYLOAD_BUF - 1;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       len = 0;
                1:       len = rhd_pkg::PAYLOAD_BUF;
                2:       len = rhd_pkg::PAYLOAD_BUF + 1;
                default: len = $urandom_range(1000, 999999);
            endcase
        end

        param_text.delete();
        put_number(sock, 20);
        param_text.push_back(($urandom_range(0, 99) < 96) ? rhd_pkg::CH_COMMA :
                             8'($urandom_range(0, 255)));
        put_number(len, 4);
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 3)) param_text.push_back(8'($urandom_range(97, 122)));
        end
        if ($urandom_range(0, 99) < 6)
        begin
            param_text.insert($urandom_range(0, param_text.size()),
                              8'($urandom_range(0, 255)));
        end

        foreach (param_text[i])
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                send_byte($urandom_range(0, 1) ? rhd_pkg::CH_CR : rhd_pkg::CH_LF);
            end
            send_byte(param_text[i]);
        end

        // Either close the list with a colon, or pad until the character limit closes it.
        if ($urandom_range(0, 99) < 88)
        begin
            if (sb.phase == rhd_pkg::PH_PARAM)
            begin
                send_byte(rhd_pkg::CH_COLON);
            end
        end
        else
        begin
            while (sb.phase == rhd_pkg::PH_PARAM)
            begin
                c = 8'($urandom_range(0, 255));
                while (c == rhd_pkg::CH_COLON || c == rhd_pkg::CH_CR || c == rhd_pkg::CH_LF)
                begin
                    c = 8'($urandom_range(0, 255));
                end
                send_byte(c);
            end
        end

        while (sb.phase == rhd_pkg::PH_PAYLOAD)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        bit paused;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Restart on '+' after a partial header, negative socket, two payload bytes.
        gap_pct = 20;
        send_byte(8'h00);
        send_text("+S+SKRPTM:-5,2:");
        send_byte(8'hFF);
        send_byte(8'h00);
        // No digit before the comma: dropped with socket 0.
        send_text("+SKRPTM:,:");
        drain_results();

        items = 0;
        while (items < RAND_ITEMS)
        begin
            if (!paused && items >= RAND_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            quiet = (items >= CALM_FROM);
            send_frame();
        end
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### filelist.f
design/rhd_pkg.sv
design/rhd_in_stage.sv
design/rhd_parser.sv
design/rhd_out_stage.sv
design/report_header_deframer.sv
dv/tb.sv
